### design/mrpt_pkg.sv
// Shared types and constants for the Miller-Rabin probable-prime tester.
// No dependencies; imported by mrpt_rem and the tester top level.
package mrpt_pkg;

  localparam int LFSR_W = 32;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int TRIALS_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_TRIAL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 1'b1;

  localparam logic [TRIALS_W-1:0]   TRIALS_RESET = 7'd4;
  localparam logic [LFSR_W-1:0]     SEED_RESET   = 32'd1;

  // One Galois LFSR step, shifting right.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
  endfunction

endpackage

### design/mrpt_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b at a time.
// Depends on nothing but its parameter; used by the tester top level.
module mrpt_mulmod #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc;
  logic [W-1:0]     a_r;
  logic [W-1:0]     b_sh;
  logic [W-1:0]     m_r;
  logic [CNT_W-1:0] cnt;
  logic             phase;
  logic             busy;
  logic [W:0]       sum;
  logic [W:0]       red;

  // Phase 0 doubles the accumulator, phase 1 adds a when the bit of b is set.
  always_comb begin
    if (phase) begin
      sum = {1'b0, acc} + (b_sh[W-1] ? {1'b0, a_r} : '0);
    end else begin
      sum = {acc, 1'b0};
    end
    red = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc   <= '0;
        a_r   <= a;
        b_sh  <= b;
        m_r   <= m;
        cnt   <= CNT_W'(W);
        phase <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= red[W-1:0];
        phase <= ~phase;
        if (phase) begin
          b_sh <= b_sh << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign result = acc;

endmodule

### design/mrpt_rem.sv
// Restoring remainder unit: LFSR word mod m, one dividend bit per cycle.
// Depends on mrpt_pkg for the LFSR width.
module mrpt_rem #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mrpt_pkg::LFSR_W-1:0] dividend,
  input  logic [W-1:0]               m,
  output logic                       done,
  output logic [W-1:0]               result
);
  import mrpt_pkg::*;

  localparam int CNT_W = $clog2(LFSR_W + 1);

  logic [W-1:0]      rem;
  logic [LFSR_W-1:0] d_sh;
  logic [W-1:0]      m_r;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [W:0]        sh;
  logic [W:0]        red;

  // Bring in the next dividend bit and subtract the modulus when it fits.
  always_comb begin
    sh  = {rem, d_sh[LFSR_W-1]};
    red = (sh >= {1'b0, m_r}) ? (sh - {1'b0, m_r}) : sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        d_sh <= dividend;
        m_r  <= m;
        cnt  <= CNT_W'(LFSR_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= red[W-1:0];
        d_sh <= d_sh << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = rem;

endmodule

### design/miller_rabin_prime_test_top.sv
// Miller-Rabin probable-prime tester: sequencer, LFSR and result register.
// Depends on mrpt_pkg, mrpt_mulmod and mrpt_rem.
//
//  channel   direction  signals                         word
//  in        input      in_valid in_ready candidate     one number to test
//  out       output     out_valid out_ready probably_prime  one verdict
//  cfg       input      cfg_we cfg_index cfg_data       one register write
//
// Corner candidates (0 to 4) are answered without trials. Otherwise the twos
// are stripped first, and each trial takes a remainder plus roughly
// (W + popcount(d) + r) modular multiplies, all on the one bit-serial
// multiplier. Reset is synchronous and loads the LFSR from the seed reset
// value.
// A new number is taken only when the sequencer is idle; a finished verdict
// waits in the output register while the next number is already accepted.
module miller_rabin_prime_test_top #(
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      candidate,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             probably_prime,
  input  logic                             cfg_we,
  input  logic [mrpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrpt_pkg::*;

  localparam int R_W = $clog2(WIDTH + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_STRIP    = 4'd1;
  localparam logic [3:0] ST_TRIAL    = 4'd2;
  localparam logic [3:0] ST_REM      = 4'd3;
  localparam logic [3:0] ST_SQ_START = 4'd4;
  localparam logic [3:0] ST_SQ_WAIT  = 4'd5;
  localparam logic [3:0] ST_MUL_WAIT = 4'd6;
  localparam logic [3:0] ST_STEP     = 4'd7;
  localparam logic [3:0] ST_CHECK    = 4'd8;
  localparam logic [3:0] ST_LOOP     = 4'd9;
  localparam logic [3:0] ST_LOOP_W   = 4'd10;
  localparam logic [3:0] ST_PASS     = 4'd11;
  localparam logic [3:0] ST_FIN      = 4'd12;

  logic [3:0]          state;
  logic [TRIALS_W-1:0] trial_count;
  logic [LFSR_W-1:0]   random_seed;
  logic [LFSR_W-1:0]   lfsr;
  logic [WIDTH-1:0]    n;
  logic [WIDTH-1:0]    d;
  logic [WIDTH-1:0]    d_sh;
  logic [WIDTH-1:0]    x;
  logic [WIDTH-1:0]    a;
  logic [R_W-1:0]      r;
  logic [R_W-1:0]      i;
  logic [R_W-1:0]      k;
  logic [TRIALS_W-1:0] t;
  logic                verdict;
  logic                mul_start;
  logic [WIDTH-1:0]    mul_a;
  logic [WIDTH-1:0]    mul_b;
  logic                mul_done;
  logic [WIDTH-1:0]    mul_res;
  logic                rem_start;
  logic                rem_done;
  logic [WIDTH-1:0]    rem_res;
  logic [LFSR_W-1:0]   lfsr_next;
  logic [WIDTH-1:0]    cand_w;
  logic [WIDTH-1:0]    n_m1;

  assign lfsr_next = lfsr_step(lfsr);
  assign cand_w    = candidate[WIDTH-1:0];
  assign n_m1      = n - 1'b1;
  assign in_ready  = (state == ST_IDLE);

  mrpt_mulmod #(.W(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (n),
    .done   (mul_done),
    .result (mul_res)
  );

  mrpt_rem #(.W(WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (lfsr),
    .m        (n - WIDTH'(4)),
    .done     (rem_done),
    .result   (rem_res)
  );

  // Configuration registers and the witness LFSR.
  always_ff @(posedge clk) begin
    if (rst) begin
      trial_count <= TRIALS_RESET;
      random_seed <= SEED_RESET;
      lfsr        <= SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIAL_COUNT: trial_count <= cfg_data[TRIALS_W-1:0];
        REG_RANDOM_SEED: begin
          random_seed <= cfg_data;
          lfsr        <= cfg_data;
        end
        default: ;
      endcase
    end else if (state == ST_TRIAL) begin
      lfsr <= lfsr_next;
    end
  end

  // Test sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      rem_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      rem_start <= 1'b0;
      // The finish state reloads the output register itself.
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            n <= cand_w;
            d <= cand_w - 1'b1;
            r <= '0;
            if (cand_w <= WIDTH'(1) || cand_w == WIDTH'(4)) begin
              verdict <= 1'b0;
              state   <= ST_FIN;
            end else if (cand_w <= WIDTH'(3)) begin
              verdict <= 1'b1;
              state   <= ST_FIN;
            end else begin
              state <= ST_STRIP;
            end
          end
        end
        ST_STRIP: begin
          if (!d[0]) begin
            d <= d >> 1;
            r <= r + 1'b1;
          end else if (trial_count == '0) begin
            verdict <= 1'b1;
            state   <= ST_FIN;
          end else begin
            t     <= '0;
            state <= ST_TRIAL;
          end
        end
        ST_TRIAL: begin
          // The LFSR steps this cycle; the remainder starts on its new value.
          rem_start <= 1'b1;
          state     <= ST_REM;
        end
        ST_REM: begin
          if (rem_done) begin
            a     <= rem_res + WIDTH'(2);
            x     <= WIDTH'(1);
            d_sh  <= d;
            k     <= R_W'(WIDTH);
            state <= ST_SQ_START;
          end
        end
        ST_SQ_START: begin
          mul_a     <= x;
          mul_b     <= x;
          mul_start <= 1'b1;
          state     <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (mul_done) begin
            x <= mul_res;
            if (d_sh[WIDTH-1]) begin
              mul_a     <= mul_res;
              mul_b     <= a;
              mul_start <= 1'b1;
              state     <= ST_MUL_WAIT;
            end else begin
              state <= ST_STEP;
            end
          end
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            x     <= mul_res;
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          d_sh <= d_sh << 1;
          k    <= k - 1'b1;
          if (k == R_W'(1)) begin
            state <= ST_CHECK;
          end else begin
            state <= ST_SQ_START;
          end
        end
        ST_CHECK: begin
          i <= R_W'(1);
          if (x == WIDTH'(1) || x == n_m1) begin
            state <= ST_PASS;
          end else begin
            state <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (i < r) begin
            mul_a     <= x;
            mul_b     <= x;
            mul_start <= 1'b1;
            state     <= ST_LOOP_W;
          end else begin
            verdict <= 1'b0;
            state   <= ST_FIN;
          end
        end
        ST_LOOP_W: begin
          if (mul_done) begin
            x <= mul_res;
            i <= i + 1'b1;
            if (mul_res == WIDTH'(1)) begin
              verdict <= 1'b0;
              state   <= ST_FIN;
            end else if (mul_res == n_m1) begin
              state <= ST_PASS;
            end else begin
              state <= ST_LOOP;
            end
          end
        end
        ST_PASS: begin
          t <= t + 1'b1;
          if (t + 1'b1 == trial_count) begin
            verdict <= 1'b1;
            state   <= ST_FIN;
          end else begin
            state <= ST_TRIAL;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            probably_prime <= verdict;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A word is accepted only from idle and moves the sequencer on.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  // A finished verdict is always placed in the output register.
  a_fin_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("verdict not delivered from the finish state");

  // A multiply start is only seen in the states that wait for the multiplier.
  a_mul_start_src: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (state == ST_SQ_WAIT || state == ST_MUL_WAIT || state == ST_LOOP_W))
    else $error("multiplier started outside a waiting state");

endmodule

### tb/testbench.sv
// Self-checking testbench for the Miller-Rabin probable-prime tester.
// Depends on mrpt_pkg and miller_rabin_prime_test_top; a local predictor
// computes each verdict and a monitor checks every output word in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mrpt_pkg::*;

  localparam int          CYCLE_LIMIT = 6_000_000;
  localparam int          SETTLE      = 50;
  localparam int          HOLD_LEN    = 3000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [31:0]           candidate;
  logic                  out_valid;
  logic                  out_ready;
  logic                  probably_prime;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: a copy of the registers and the witness LFSR.
  logic [TRIALS_W-1:0] pred_trials;
  logic [LFSR_W-1:0]   pred_seed;
  logic [LFSR_W-1:0]   pred_lfsr;

  bit   verdict_q[$];
  int   mismatches;
  int   words_checked;
  int   primes_seen;
  int   cycles;
  bit   no_idle;
  bit   hold_req;

  miller_rabin_prime_test_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .candidate      (candidate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .probably_prime (probably_prime),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter with a hard limit on the run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [63:0] prod;
    prod = {32'd0, a} * {32'd0, b};
    return 32'(prod % {32'd0, m});
  endfunction

  function automatic logic [31:0] powmod(logic [31:0] base, logic [31:0] ex, logic [31:0] m);
    logic [31:0] acc;
    acc = 32'd1 % m;
    base = base % m;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, base, m);
      ex = ex >> 1;
      base = mulmod(base, base, m);
    end
    return acc;
  endfunction

  function automatic logic [31:0] lfsr_next(logic [31:0] v);
    return v[0] ? ((v >> 1) ^ 32'h8020_0003) : (v >> 1);
  endfunction

  // One witness trial; steps the predictor LFSR once.
  function bit witness_passes(logic [31:0] n, logic [31:0] d, int r);
    logic [31:0] a;
    logic [31:0] x;
    pred_lfsr = lfsr_next(pred_lfsr);
    a = 32'd2 + (pred_lfsr % (n - 32'd4));
    x = powmod(a, d, n);
    if (x == 32'd1 || x == n - 32'd1) return 1'b1;
    for (int i = 1; i < r; i++) begin
      x = mulmod(x, x, n);
      if (x == 32'd1) return 1'b0;
      if (x == n - 32'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected verdict for one candidate, advancing the predictor state.
  function bit predict_verdict(logic [31:0] n);
    logic [31:0] d;
    int          r;
    if (n <= 32'd1 || n == 32'd4) return 1'b0;
    if (n <= 32'd3) return 1'b1;
    d = n - 32'd1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    for (int t = 0; t < int'(pred_trials); t++)
      if (!witness_passes(n, d, r)) return 1'b0;
    return 1'b1;
  endfunction

  // Slow exact primality check, used only to build stimulus.
  function automatic bit exact_prime(logic [31:0] n);
    longint unsigned i;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (!n[0]) return 1'b0;
    for (i = 3; i * i <= longint'(n); i += 2)
      if (longint'(n) % i == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] prime_from(logic [31:0] start);
    logic [31:0] n;
    n = start | 32'd1;
    while (!exact_prime(n)) n = n - 32'd2;
    return n;
  endfunction

  task automatic report_mismatch(string what, bit got, bit want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic int gap_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(20, 200);
  endfunction

  // Send one word on the input channel and queue its expected verdict.
  task automatic send_number(logic [31:0] n);
    int gap;
    in_valid  <= 1'b1;
    candidate <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict_q.insert(verdict_q.size(), predict_verdict(n));
    gap = gap_len();
    if (gap > 0) begin
      in_valid  <= 1'b0;
      candidate <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write, only issued once the block has gone idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= $urandom();
    if (idx == REG_TRIAL_COUNT) begin
      pred_trials = val[TRIALS_W-1:0];
    end else begin
      pred_seed = val;
      pred_lfsr = val;
    end
  endtask

  // Output monitor: checks each word and drives out_ready.
  initial begin
    int stall_left;
    int hold_left;
    bit want;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected word", probably_prime, 1'b0);
        end else begin
          want = verdict_q.pop_front();
          if (probably_prime !== want) report_mismatch("probably_prime", probably_prime, want);
          words_checked++;
          if (want) primes_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 8) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 300);
        out_ready <= 1'b0;
      end
    end
  end

  // Corner candidates answered without trials.
  task automatic test_corners();
    for (int n = 0; n <= 4; n++) send_number(32'(n));
  endtask

  // Largest values, small primes and composites at the reset settings.
  task automatic test_extremes();
    send_number(32'hFFFF_FFFF);
    send_number(32'hFFFF_FFFB);
    send_number(32'd5);
    send_number(32'd9);
    send_number(32'hFFFF_FFFE);
    send_number(32'd561);
  endtask

  // Zero seed keeps the witness at 2, so the strong pseudoprime 2047 passes.
  task automatic test_zero_seed();
    write_reg(REG_RANDOM_SEED, 32'd0);
    send_number(32'd2047);
    send_number(32'd2053);
    send_number(32'd2049);
    write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
    send_number(32'd2047);
  endtask

  // Trial counts of zero, 64 and the top of the field.
  task automatic test_trial_counts();
    write_reg(REG_TRIAL_COUNT, 32'hFFFF_FF00);
    send_number(32'd1001);
    send_number(32'd4);
    write_reg(REG_TRIAL_COUNT, 32'd64);
    send_number(32'hFFFF_FFFB);
    write_reg(REG_TRIAL_COUNT, 32'hFFFF_FFFF);
    send_number(32'hFFFF_FFF0);
    send_number(32'd3);
  endtask

  // Receiver holds off while cheap words keep arriving.
  task automatic test_backpressure();
    write_reg(REG_TRIAL_COUNT, 32'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_number(32'($urandom_range(0, 4)));
    send_number(32'd10);
    wait_drained();
  endtask

  // Random words: mostly primes and products of primes, with some noise.
  task automatic test_random();
    logic [31:0] n;
    logic [15:0] p;
    logic [15:0] q;
    int          kind;
    for (int grp = 0; grp < 4; grp++) begin
      write_reg(REG_TRIAL_COUNT, 32'($urandom_range(1, 4)));
      write_reg(REG_RANDOM_SEED, $urandom() | 32'd1);
      no_idle = (grp == 2);
      for (int i = 0; i < 19; i++) begin
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          n = prime_from($urandom());
        end else if (kind < 6) begin
          p = 16'(prime_from(32'($urandom_range(3, 65535))));
          q = 16'(prime_from(32'($urandom_range(3, 65535))));
          n = {16'd0, p} * {16'd0, q};
        end else if (kind < 8) begin
          n = $urandom();
        end else begin
          n = $urandom_range(0, 300);
        end
        send_number(n);
      end
      no_idle = 1'b0;
    end
  endtask

  // Main sequence.
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    candidate     = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    words_checked = 0;
    primes_seen   = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    pred_trials   = TRIALS_RESET;
    pred_seed     = SEED_RESET;
    pred_lfsr     = SEED_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners();
    test_extremes();
    test_zero_seed();
    test_trial_counts();
    test_backpressure();
    test_random();
    wait_drained();

    $display("checked %0d verdicts (%0d probably prime) over corners, extremes,",
             words_checked, primes_seen);
    $display("zero seed, trial counts 0 to 127, output hold-off and random numbers");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
